// ----- sv/twc_pkg.sv -----
// Package for the touch wheel centroid decoder: constants, state codes,
// control struct and the CORDIC arctangent table. No dependencies.
package twc_pkg;

  localparam int PADS_DEF     = 12;
  localparam int FRAC_BITS    = 8;
  localparam int CORDIC_STEPS = 16;
  localparam int IDX_W        = $clog2(CORDIC_STEPS);
  localparam int UNIT_START   = 9949;
  localparam int FALLBACK_TOP = 32;
  localparam int ACTIVE_PEAK  = 10;
  localparam int CX_W         = 35;
  localparam int CZ_W         = 33;
  localparam int MA_W         = 33;
  localparam int MB_W         = 12;
  localparam int MP_W         = MA_W + MB_W;
  localparam int PHASE_W      = 32;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  localparam logic REG_RING_COUNT = 1'b0;
  localparam logic REG_INVERT     = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROT,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_FRAME,
    ST_VEC,
    ST_MULP,
    ST_POS,
    ST_UPD,
    ST_UP,
    ST_DN,
    ST_OUT,
    ST_READ
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic vec;
  } cordic_ctl_t;

  function automatic logic [31:0] turn_atan(input logic [IDX_W-1:0] i);
    logic [31:0] a;
    unique case (i)
      4'd0:    a = 32'h2000_0000;
      4'd1:    a = 32'h12E4_051E;
      4'd2:    a = 32'h09FB_385B;
      4'd3:    a = 32'h0511_11D4;
      4'd4:    a = 32'h028B_0D43;
      4'd5:    a = 32'h0145_D7E1;
      4'd6:    a = 32'h00A2_F61E;
      4'd7:    a = 32'h0051_7C55;
      4'd8:    a = 32'h0028_BE53;
      4'd9:    a = 32'h0014_5F2F;
      4'd10:   a = 32'h000A_2F98;
      4'd11:   a = 32'h0005_17CC;
      4'd12:   a = 32'h0002_8BE6;
      4'd13:   a = 32'h0001_45F3;
      4'd14:   a = 32'h0000_A2F9;
      default: a = 32'h0000_517D;
    endcase
    return a;
  endfunction

endpackage

// ----- sv/twc_div.sv -----
// Bit-serial restoring divider: phase = (slot << 32) / count.
// Depends on twc_pkg.
module twc_div #(
  parameter int CW = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [3:0]                     slot,
  input  logic [CW-1:0]                  count,
  output logic                           busy,
  output logic [twc_pkg::PHASE_W-1:0]    q
);

  logic [CW:0] rem;
  logic [CW:0] trial;
  logic        ge;
  logic [5:0]  cnt;
  logic        run;

  assign trial = {rem[CW-1:0], 1'b0};
  assign ge    = trial >= {1'b0, count};
  assign busy  = run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      run <= 1'b1;
      cnt <= '0;
    end else if (run) begin
      cnt <= cnt + 6'd1;
      if (cnt == 6'(twc_pkg::PHASE_W - 1)) run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= (CW+1)'(slot);
      q   <= '0;
    end else if (run) begin
      rem <= ge ? trial - {1'b0, count} : trial;
      q   <= {q[twc_pkg::PHASE_W-2:0], ge};
    end
  end

endmodule

// ----- sv/twc_cordic.sv -----
// Shared CORDIC iteration unit, rotating or vectoring, one step per cycle.
// Depends on twc_pkg (table, widths, control struct).
module twc_cordic (
  input  logic                              clk,
  input  twc_pkg::cordic_ctl_t              ctl,
  input  logic [twc_pkg::IDX_W-1:0]         idx,
  input  logic signed [twc_pkg::CX_W-1:0]   x0,
  input  logic signed [twc_pkg::CX_W-1:0]   y0,
  input  logic signed [twc_pkg::CZ_W-1:0]   z0,
  output logic signed [twc_pkg::CX_W-1:0]   x,
  output logic signed [twc_pkg::CX_W-1:0]   y,
  output logic signed [twc_pkg::CZ_W-1:0]   z
);

  logic                            ccw;
  logic signed [twc_pkg::CX_W-1:0] xs;
  logic signed [twc_pkg::CX_W-1:0] ys;
  logic signed [twc_pkg::CZ_W-1:0] a;

  assign ccw = ctl.vec ? y[twc_pkg::CX_W-1] : !z[twc_pkg::CZ_W-1];
  assign xs  = x >>> idx;
  assign ys  = y >>> idx;
  assign a   = $signed({1'b0, twc_pkg::turn_atan(idx)});

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x <= x0;
      y <= y0;
      z <= z0;
    end else if (ctl.step) begin
      x <= ccw ? x - ys : x + ys;
      y <= ccw ? y + xs : y - xs;
      z <= ccw ? z - a : z + a;
    end
  end

endmodule

// ----- sv/twc_mul.sv -----
// Shared signed multiplier with registered product.
// Depends on twc_pkg (operand widths).
module twc_mul (
  input  logic                              clk,
  input  logic signed [twc_pkg::MA_W-1:0]   a,
  input  logic signed [twc_pkg::MB_W-1:0]   b,
  output logic signed [twc_pkg::MP_W-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ----- sv/touch_wheel_centroid_decoder.sv -----
// Touch wheel centroid decoder top level: sequencer, sums, debounce, steps.
// Depends on twc_pkg, twc_div, twc_cordic, twc_mul.
//
//  channel | handshake           | words
//  in      | in_valid/in_ready   | func, ring_slot, baseline/filtered, touched, last
//  out     | out_valid/out_ready | step_delta, accum_steps, flags, wheel_position
//  cfg     | cfg_write           | cfg_index, cfg_data
//
// Sample in ring: divider (32 quotient bits, then the CORDIC load), 16 CORDIC
// rotations and the multiply states M0 to M4, then idle before the next word.
// Frame end adds a load, 16 vectoring steps, MULP, POS, UPD, UP, DN and OUT,
// with UP or DN held per whole step; no strength or a zero sum skips VEC.
// Read word: the READ state, then idle. A held result stalls output and read.
// in_ready is high only in idle; the next word can enter while a result waits.
// Synchronous reset sets sequencer, config, sums and steps; no clearing pass.
module touch_wheel_centroid_decoder #(
  parameter int PADS = twc_pkg::PADS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [3:0]         ring_slot,
  input  logic [9:0]         baseline_value,
  input  logic [9:0]         filtered_value,
  input  logic [11:0]        touched_bits,
  input  logic               last_in_frame,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [4:0]  step_delta,
  output logic signed [15:0] accum_steps,
  output logic               wheel_active,
  output logic               position_valid,
  output logic [11:0]        wheel_position,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_data
);

  localparam int CW   = $clog2(PADS + 1);
  localparam int FB   = twc_pkg::FRAC_BITS;
  localparam int PSW  = FB + CW;
  localparam int DW   = PSW + 3;
  localparam int XW   = twc_pkg::CX_W;
  localparam int ZW   = twc_pkg::CZ_W;
  localparam int IW   = twc_pkg::IDX_W;

  twc_pkg::state_t state, state_next;

  logic [3:0]    ring_count;
  logic          invert_direction;
  logic [CW-1:0] count;

  logic [3:0]         s_slot;
  logic signed [10:0] s_main;
  logic signed [10:0] s_fb;
  logic               take_m, take_f, s_last;
  logic [11:0]        s_touched;
  logic               flip;

  logic signed [31:0] sum_x_main, sum_y_main, sum_x_fallback, sum_y_fallback;
  logic [9:0]         peak_main;
  logic [5:0]         peak_fallback;
  logic               active_flag;
  logic [1:0]         active_run, quiet_run;
  logic [PSW-1:0]     previous_position;
  logic               previous_valid;
  logic signed [DW-1:0] fraction_move;
  logic signed [15:0] step_total;
  logic signed [5:0]  step_cnt;
  logic [PSW-1:0]     pos;
  logic               frame_valid;
  logic               angle_zero;
  logic [IW-1:0]      idx;

  logic                      div_start, div_busy;
  logic [31:0]               div_q;
  twc_pkg::cordic_ctl_t      cctl;
  logic signed [XW-1:0]      cx0, cy0, cord_x, cord_y;
  logic signed [ZW-1:0]      cz0, cord_z;
  logic signed [twc_pkg::MA_W-1:0] mul_a;
  logic signed [twc_pkg::MB_W-1:0] mul_b;
  logic signed [twc_pkg::MP_W-1:0] prod;

  logic               accept, out_free, in_range;
  logic signed [10:0] sm_in, sf_in;
  logic [31:0]        phase_adj;
  logic               flip_in;
  logic signed [32:0] ux;
  logic signed [32:0] uy;
  logic               sel_main;
  logic [9:0]         peak_sel;
  logic signed [31:0] sx_sel, sy_sel;
  logic               hit;
  logic [1:0]         ar_new, qr_new;
  logic               act_new;
  logic signed [DW-1:0] full, halfring, half, one, diff0, diff1, diff2;

  // ---------------------------------------------------------------- units
  twc_div #(.CW(CW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .slot(ring_slot), .count(count),
    .busy(div_busy), .q(div_q)
  );

  twc_cordic u_cordic (
    .clk(clk), .ctl(cctl), .idx(idx), .x0(cx0), .y0(cy0), .z0(cz0),
    .x(cord_x), .y(cord_y), .z(cord_z)
  );

  twc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  // ---------------------------------------------------------------- misc logic
  always_comb begin
    if (ring_count == 4'd0)                 count = CW'(1);
    else if ({1'b0, ring_count} > 5'(PADS)) count = CW'(PADS);
    else                                    count = CW'(ring_count);
  end

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign in_range = {1'b0, ring_slot} < 5'(count);
  assign sm_in    = $signed({1'b0, baseline_value}) - $signed({1'b0, filtered_value});
  assign sf_in    = 11'(twc_pkg::FALLBACK_TOP) - $signed({1'b0, filtered_value});

  assign phase_adj = div_q + 32'h4000_0000;
  assign flip_in   = phase_adj[31];

  assign ux = flip ? -33'(cord_x) : 33'(cord_x);
  assign uy = flip ? -33'(cord_y) : 33'(cord_y);

  assign sel_main = peak_main != 10'd0;
  assign peak_sel = sel_main ? peak_main : 10'(peak_fallback);
  assign sx_sel   = sel_main ? sum_x_main : sum_x_fallback;
  assign sy_sel   = sel_main ? sum_y_main : sum_y_fallback;

  assign hit     = (s_touched != 12'd0) || (peak_sel >= 10'(twc_pkg::ACTIVE_PEAK));
  assign ar_new  = hit ? ((active_run == 2'd3) ? 2'd3 : active_run + 2'd1) : 2'd0;
  assign qr_new  = hit ? 2'd0 : ((quiet_run == 2'd3) ? 2'd3 : quiet_run + 2'd1);
  always_comb begin
    act_new = active_flag;
    if (!active_flag && ar_new >= 2'd2) act_new = 1'b1;
    if (active_flag && qr_new == 2'd3)  act_new = 1'b0;
  end

  assign full     = DW'(count) <<< FB;
  assign halfring = DW'(count) <<< (FB - 1);
  assign half     = DW'(1) <<< (FB - 1);
  assign one      = DW'(1) <<< FB;
  assign diff0    = DW'(pos) - DW'(previous_position);
  always_comb begin
    if (diff0 > halfring)       diff1 = diff0 - full;
    else if (diff0 < -halfring) diff1 = diff0 + full;
    else                        diff1 = diff0;
  end
  assign diff2 = invert_direction ? -diff1 : diff1;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      twc_pkg::ST_IDLE: begin
        if (accept) begin
          if (func == twc_pkg::FUNC_READ) state_next = twc_pkg::ST_READ;
          else if (in_range)              state_next = twc_pkg::ST_DIV;
          else if (last_in_frame)         state_next = twc_pkg::ST_FRAME;
        end
      end
      twc_pkg::ST_DIV:   if (!div_busy) state_next = twc_pkg::ST_ROT;
      twc_pkg::ST_ROT:   if (idx == IW'(twc_pkg::CORDIC_STEPS - 1)) state_next = twc_pkg::ST_M0;
      twc_pkg::ST_M0:    state_next = twc_pkg::ST_M1;
      twc_pkg::ST_M1:    state_next = twc_pkg::ST_M2;
      twc_pkg::ST_M2:    state_next = twc_pkg::ST_M3;
      twc_pkg::ST_M3:    state_next = twc_pkg::ST_M4;
      twc_pkg::ST_M4:    state_next = s_last ? twc_pkg::ST_FRAME : twc_pkg::ST_IDLE;
      twc_pkg::ST_FRAME: begin
        if (peak_sel == 10'd0 || (sx_sel == 32'sd0 && sy_sel == 32'sd0))
          state_next = twc_pkg::ST_MULP;
        else
          state_next = twc_pkg::ST_VEC;
      end
      twc_pkg::ST_VEC:   if (idx == IW'(twc_pkg::CORDIC_STEPS - 1)) state_next = twc_pkg::ST_MULP;
      twc_pkg::ST_MULP:  state_next = twc_pkg::ST_POS;
      twc_pkg::ST_POS:   state_next = twc_pkg::ST_UPD;
      twc_pkg::ST_UPD:   state_next = twc_pkg::ST_UP;
      twc_pkg::ST_UP:    if (fraction_move < half) state_next = twc_pkg::ST_DN;
      twc_pkg::ST_DN:    if (fraction_move > -half) state_next = twc_pkg::ST_OUT;
      twc_pkg::ST_OUT:   if (out_free) state_next = twc_pkg::ST_IDLE;
      twc_pkg::ST_READ:  if (out_free) state_next = twc_pkg::ST_IDLE;
      default:           state_next = twc_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- unit control
  always_comb begin
    in_ready  = state == twc_pkg::ST_IDLE;
    div_start = accept && func == twc_pkg::FUNC_SAMPLE && in_range;
    cctl      = '0;
    cx0       = XW'(twc_pkg::UNIT_START);
    cy0       = '0;
    cz0       = ZW'($signed({flip_in ^ div_q[31], div_q[30:0]}));
    mul_a     = ux;
    mul_b     = 12'(s_main);
    unique case (state)
      twc_pkg::ST_DIV: cctl.load = !div_busy;
      twc_pkg::ST_ROT: cctl.step = 1'b1;
      twc_pkg::ST_M1:  mul_a = uy;
      twc_pkg::ST_M2:  mul_b = 12'(s_fb);
      twc_pkg::ST_M3: begin
        mul_a = uy;
        mul_b = 12'(s_fb);
      end
      twc_pkg::ST_FRAME: begin
        cctl.load = 1'b1;
        cctl.vec  = 1'b1;
        cx0 = sx_sel[31] ? -XW'(sx_sel) : XW'(sx_sel);
        cy0 = sx_sel[31] ? -XW'(sy_sel) : XW'(sy_sel);
        cz0 = sx_sel[31] ? ZW'(33'h0_8000_0000) : '0;
      end
      twc_pkg::ST_VEC: begin
        cctl.step = 1'b1;
        cctl.vec  = 1'b1;
      end
      twc_pkg::ST_MULP: begin
        mul_a = angle_zero ? '0 : $signed({1'b0, cord_z[31:0]});
        mul_b = $signed(12'(count));
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= twc_pkg::ST_IDLE;
      ring_count <= 4'd12;
      invert_direction <= 1'b0;
      idx <= '0;
      sum_x_main <= '0;
      sum_y_main <= '0;
      sum_x_fallback <= '0;
      sum_y_fallback <= '0;
      peak_main <= '0;
      peak_fallback <= '0;
      active_flag <= 1'b0;
      active_run <= '0;
      quiet_run <= '0;
      previous_position <= '0;
      previous_valid <= 1'b0;
      fraction_move <= '0;
      step_total <= '0;
      step_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        if (cfg_index == twc_pkg::REG_RING_COUNT) ring_count <= cfg_data;
        else                                      invert_direction <= cfg_data[0];
      end
      if ((state == twc_pkg::ST_OUT || state == twc_pkg::ST_READ) && out_free)
        out_valid <= 1'b1;
      else if (out_valid && out_ready)
        out_valid <= 1'b0;

      if (cctl.load)      idx <= '0;
      else if (cctl.step) idx <= idx + IW'(1);

      unique case (state)
        twc_pkg::ST_M1: if (take_m) sum_x_main <= sum_x_main + prod[31:0];
        twc_pkg::ST_M2: if (take_m) sum_y_main <= sum_y_main + prod[31:0];
        twc_pkg::ST_M3: if (take_f) sum_x_fallback <= sum_x_fallback + prod[31:0];
        twc_pkg::ST_M4: begin
          if (take_f) sum_y_fallback <= sum_y_fallback + prod[31:0];
          if (take_m && s_main[9:0] > peak_main)    peak_main <= s_main[9:0];
          if (take_f && s_fb[5:0] > peak_fallback)  peak_fallback <= s_fb[5:0];
        end
        twc_pkg::ST_UPD: begin
          active_run  <= ar_new;
          quiet_run   <= qr_new;
          active_flag <= act_new;
          step_cnt    <= '0;
          if (act_new && frame_valid) begin
            if (previous_valid) fraction_move <= fraction_move + diff2;
            previous_position <= pos;
            previous_valid    <= 1'b1;
          end else begin
            previous_valid <= 1'b0;
            fraction_move  <= '0;
          end
          sum_x_main <= '0;
          sum_y_main <= '0;
          sum_x_fallback <= '0;
          sum_y_fallback <= '0;
          peak_main <= '0;
          peak_fallback <= '0;
        end
        twc_pkg::ST_UP: begin
          if (fraction_move >= half) begin
            fraction_move <= fraction_move - one;
            step_cnt <= step_cnt + 6'sd1;
            if (step_total != 16'sh7FFF) step_total <= step_total + 16'sd1;
          end
        end
        twc_pkg::ST_DN: begin
          if (fraction_move <= -half) begin
            fraction_move <= fraction_move + one;
            step_cnt <= step_cnt - 6'sd1;
            if (step_total != 16'sh8000) step_total <= step_total - 16'sd1;
          end
        end
        twc_pkg::ST_READ: if (out_free) step_total <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_slot    <= ring_slot;
      s_main    <= sm_in;
      s_fb      <= sf_in;
      take_m    <= !sm_in[10] && sm_in != 11'sd0;
      take_f    <= sf_in >= 11'sd2;
      s_last    <= last_in_frame;
      s_touched <= touched_bits;
    end
    if (state == twc_pkg::ST_DIV && !div_busy) flip <= flip_in;
    if (state == twc_pkg::ST_FRAME) begin
      frame_valid <= peak_sel != 10'd0;
      angle_zero  <= peak_sel == 10'd0 || (sx_sel == 32'sd0 && sy_sel == 32'sd0);
    end
    if (state == twc_pkg::ST_POS) pos <= prod[32-FB +: PSW];
    if (state == twc_pkg::ST_OUT && out_free) begin
      if (step_cnt > 6'sd15)       step_delta <= 5'sd15;
      else if (step_cnt < -6'sd16) step_delta <= 5'sb1_0000;
      else                         step_delta <= step_cnt[4:0];
      accum_steps    <= step_total;
      wheel_active   <= active_flag;
      position_valid <= frame_valid;
      wheel_position <= frame_valid ? 12'(pos) : 12'd0;
    end
    if (state == twc_pkg::ST_READ && out_free) begin
      step_delta     <= '0;
      accum_steps    <= step_total;
      wheel_active   <= active_flag;
      position_valid <= 1'b0;
      wheel_position <= '0;
    end
  end

  // ---------------------------------------------------------------- checks
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    state == twc_pkg::ST_IDLE |-> (fraction_move >= -half && fraction_move <= half))
    else $error("fraction out of range");

  a_frac_clear: assert property (@(posedge clk) disable iff (rst)
    (state == twc_pkg::ST_IDLE && !previous_valid) |-> fraction_move == '0)
    else $error("fraction kept without previous position");

  a_main_empty: assert property (@(posedge clk) disable iff (rst)
    (state == twc_pkg::ST_IDLE && peak_main == 10'd0) |->
      (sum_x_main == 32'sd0 && sum_y_main == 32'sd0))
    else $error("main sum without main peak");

  a_debounce: assert property (@(posedge clk) disable iff (rst)
    !(active_flag && quiet_run == 2'd3))
    else $error("active flag held through quiet run");

  a_slot_used: assert property (@(posedge clk) disable iff (rst)
    (state == twc_pkg::ST_M0) |-> ({1'b0, s_slot} < 5'(count)))
    else $error("sample outside ring accumulated");

endmodule
